[src/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define HVMB_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("hvmb assertion failed");

// next-cycle implication
`define HVMB_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("hvmb assertion failed");

`endif

[src/hvmb_pkg.sv]
// types and constants of the hypervector majority bundle
`timescale 1ns / 1ps
package hvmb_pkg;

   localparam int WORD_W      = 64;
   localparam int POSITION_W  = 7;
   localparam int VCOUNT_W    = 5;
   localparam int CSR_INDEX_W = 2;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_VECTOR_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIE_SEED     = 2'd1;

   // splitmix64 constants
   localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_W-1:0] MIX_ONE     = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_W-1:0] MIX_TWO     = 64'h94D0_49BB_1331_11EB;
   localparam int SHIFT_ONE   = 30;
   localparam int SHIFT_TWO   = 27;
   localparam int SHIFT_THREE = 31;

   typedef enum logic [1:0] {
      MIX_IDLE,
      MIX_MUL,
      MIX_SHUF,
      MIX_EMIT
   } mix_op_type;

   // partial products of a 64 x 64 low-half multiply
   typedef enum logic [1:0] {
      MUL_LOW,
      MUL_CROSS_A,
      MUL_CROSS_B
   } mul_step_type;

   typedef struct packed {
      logic         word_take;
      mix_op_type   mix_op;
      mul_step_type mul_step;
      logic         mul_second;
   } hvmb_cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } hvmb_sts_type;

endpackage

[src/hvmb_ifs.sv]
// handshake channels of the hypervector majority bundle
`timescale 1ns / 1ps

interface hvmb_req_if import hvmb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] vector_word;
   logic              start_of_bundle;

   modport source (output valid, output vector_word, output start_of_bundle, input ready);
   modport sink   (input valid, input vector_word, input start_of_bundle, output ready);
endinterface

interface hvmb_rsp_if import hvmb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [WORD_W-1:0]     majority_word;
   logic [POSITION_W-1:0] word_position;

   modport source (output valid, output majority_word, output word_position, input ready);
   modport sink   (input valid, input majority_word, input word_position, output ready);
endinterface

interface hvmb_csr_if import hvmb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [WORD_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/hvmb_datapath.sv]
// vote counters, tie generator and output register of the majority bundle
`timescale 1ns / 1ps
module hvmb_datapath import hvmb_pkg::*; #(
   parameter int HV_WORDS   = 128,
   parameter int MAX_PLANES = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [WORD_W-1:0]      vector_word,
   input  logic                   start_of_bundle,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_data,
   input  hvmb_cmd_type           cmd,
   output hvmb_sts_type           sts,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WORD_W-1:0]      majority_word,
   output logic [POSITION_W-1:0]  word_position
);

   localparam int POS_W = (HV_WORDS > 1) ? $clog2(HV_WORDS) : 1;
   localparam logic [MAX_PLANES-1:0] CAP = '1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(HV_WORDS - 1);

   logic [VCOUNT_W-1:0]   vcount_ff;
   logic [WORD_W-1:0]     seed_ff;
   logic [MAX_PLANES-1:0] count_ff [WORD_W];
   logic [MAX_PLANES-1:0] count_sum [WORD_W];
   logic [MAX_PLANES-1:0] arrivals_ff;
   logic [MAX_PLANES-1:0] arrivals_in;
   logic [POS_W-1:0]      pos_ff;
   logic [WORD_W-1:0]     gen_ff;
   logic [WORD_W-1:0]     gen_base;
   logic [WORD_W-1:0]     gen_in;
   logic [WORD_W-1:0]     op_ff;
   logic [WORD_W-1:0]     acc_ff;
   logic [WORD_W-1:0]     rsp_word_ff;
   logic [POSITION_W-1:0] rsp_pos_ff;
   logic                  rsp_valid_ff;

   logic [MAX_PLANES-1:0] eff_n;
   logic [MAX_PLANES-1:0] half;
   logic                  even;
   logic [WORD_W-1:0]     tie;
   logic [WORD_W-1:0]     result;
   logic [WORD_W-1:0]     konst;
   logic [31:0]           mul_a;
   logic [31:0]           mul_b;
   logic [WORD_W-1:0]     mul_prod;

   // vector count of zero acts as one, and is capped by the counter planes
   always_comb begin
      if (vcount_ff == '0) begin
         eff_n = MAX_PLANES'(1);
      end else if (32'(vcount_ff) > 32'(CAP)) begin
         eff_n = CAP;
      end else begin
         eff_n = MAX_PLANES'(vcount_ff);
      end
   end

   assign half = eff_n >> 1;
   assign even = ~eff_n[0];

   // per-bit add of the incoming word
   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         count_sum[b] = (start_of_bundle ? '0 : count_ff[b]) + MAX_PLANES'(vector_word[b]);
      end
   end

   assign arrivals_in = (start_of_bundle ? '0 : arrivals_ff) + MAX_PLANES'(1);
   assign gen_base    = start_of_bundle ? seed_ff : gen_ff;
   assign gen_in      = gen_base + GOLDEN_STEP;

   // one 32 x 32 partial product a cycle
   assign konst    = cmd.mul_second ? MIX_TWO : MIX_ONE;
   assign mul_a    = (cmd.mul_step == MUL_CROSS_A) ? op_ff[63:32] : op_ff[31:0];
   assign mul_b    = (cmd.mul_step == MUL_CROSS_B) ? konst[63:32] : konst[31:0];
   assign mul_prod = mul_a * mul_b;

   assign tie = acc_ff ^ (acc_ff >> SHIFT_THREE);

   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         if (count_ff[b] > half) begin
            result[b] = 1'b1;
         end else if (even && (count_ff[b] == half)) begin
            result[b] = tie[b];
         end else begin
            result[b] = 1'b0;
         end
      end
   end

   assign sts.last     = (arrivals_in >= eff_n);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= VCOUNT_W'(1);
         seed_ff      <= '0;
         arrivals_ff  <= '0;
         pos_ff       <= '0;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < WORD_W; b++) begin
            count_ff[b] <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_VECTOR_COUNT: vcount_ff <= csr_data[VCOUNT_W-1:0];
               CSR_TIE_SEED:     seed_ff   <= csr_data;
               default:          ;
            endcase
         end

         if (rsp_ready && (cmd.mix_op != MIX_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (cmd.word_take) begin
            for (int b = 0; b < WORD_W; b++) begin
               count_ff[b] <= count_sum[b];
            end
            if (start_of_bundle) begin
               pos_ff <= '0;
            end
            if (sts.last) begin
               arrivals_ff <= '0;
               gen_ff      <= gen_in;
               op_ff       <= gen_in ^ (gen_in >> SHIFT_ONE);
            end else begin
               arrivals_ff <= arrivals_in;
               gen_ff      <= gen_base;
            end
         end

         unique case (cmd.mix_op)
            MIX_MUL: begin
               if (cmd.mul_step == MUL_LOW) begin
                  acc_ff <= mul_prod;
               end else begin
                  acc_ff[63:32] <= acc_ff[63:32] + mul_prod[31:0];
               end
            end
            MIX_SHUF: begin
               op_ff <= acc_ff ^ (acc_ff >> SHIFT_TWO);
            end
            MIX_EMIT: begin
               rsp_word_ff  <= result;
               rsp_pos_ff   <= POSITION_W'(pos_ff);
               rsp_valid_ff <= 1'b1;
               pos_ff       <= (pos_ff == POS_LAST) ? '0 : pos_ff + POS_W'(1);
               for (int b = 0; b < WORD_W; b++) begin
                  count_ff[b] <= '0;
               end
            end
            MIX_IDLE: ;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign majority_word = rsp_word_ff;
   assign word_position = rsp_pos_ff;

endmodule

[src/hvmb_ctrl.sv]
// sequencer of the majority bundle: word intake, tie mix and result hand-off
`timescale 1ns / 1ps
module hvmb_ctrl import hvmb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  hvmb_sts_type sts,
   output hvmb_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX_ONE,
      ST_SHUFFLE,
      ST_MIX_TWO,
      ST_EMIT
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   mul_step_type   step_ff;
   mul_step_type   step_in;
   mul_step_type   step_next;
   logic           ready_ff;
   logic           ready_in;

   always_comb begin
      unique case (step_ff)
         MUL_LOW:     step_next = MUL_CROSS_A;
         MUL_CROSS_A: step_next = MUL_CROSS_B;
         default:     step_next = MUL_LOW;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      ready_in       = ready_ff;
      cmd.word_take  = 1'b0;
      cmd.mix_op     = MIX_IDLE;
      cmd.mul_step   = step_ff;
      cmd.mul_second = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.word_take = req_valid && ready_ff;
            if (cmd.word_take && sts.last) begin
               state_in = ST_MIX_ONE;
               step_in  = MUL_LOW;
               ready_in = 1'b0;
            end
         end
         ST_MIX_ONE: begin
            cmd.mix_op = MIX_MUL;
            step_in    = step_next;
            if (step_ff == MUL_CROSS_B) begin
               state_in = ST_SHUFFLE;
            end
         end
         ST_SHUFFLE: begin
            cmd.mix_op = MIX_SHUF;
            state_in   = ST_MIX_TWO;
            step_in    = MUL_LOW;
         end
         ST_MIX_TWO: begin
            cmd.mix_op     = MIX_MUL;
            cmd.mul_second = 1'b1;
            step_in        = step_next;
            if (step_ff == MUL_CROSS_B) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.mix_op = MIX_EMIT;
               state_in   = ST_IDLE;
               ready_in   = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= MUL_LOW;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

[src/hypervector_majority_bundle.sv]
// top level of the hypervector majority bundle: bitwise vote over streamed 64-bit words
// a word that does not close a position is taken every cycle; a closing word starts a
// splitmix64 mix on one shared 32 x 32 multiplier, followed by the load of the result
// register; the input is held off from the closing word until that load, and a stalled
// result register holds the load state and so delays both the result and further intake
// synchronous active-high reset clears counters, position, tie state and sets vector_count 1
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hypervector_majority_bundle import hvmb_pkg::*; #(
   parameter int HV_WORDS   = 128,
   parameter int MAX_PLANES = 5
) (
   input logic      clock,
   input logic      reset,
   hvmb_req_if.sink   req_if,
   hvmb_rsp_if.source rsp_if,
   hvmb_csr_if.sink   csr_if
);

   hvmb_cmd_type cmd;
   hvmb_sts_type sts;
   logic         req_ready;
   logic         rsp_valid;
   logic         emitting;

   // config always accepted; to be written only while no word is in flight, unenforced
   assign csr_if.ready = 1'b1;

   // sequencer: holds off the input while the tie word is mixed and the result is parked
   hvmb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // counters, tie generator, multiplier and output register
   hvmb_datapath #(
      .HV_WORDS   (HV_WORDS),
      .MAX_PLANES (MAX_PLANES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .vector_word     (req_if.vector_word),
      .start_of_bundle (req_if.start_of_bundle),
      .csr_write       (csr_if.valid),
      .csr_index       (csr_if.index),
      .csr_data        (csr_if.data),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_if.ready),
      .majority_word   (rsp_if.majority_word),
      .word_position   (rsp_if.word_position)
   );

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;
   assign emitting     = (cmd.mix_op == MIX_EMIT);

   // a closing word stops intake until its result is parked
   `HVMB_ASSERT_NEXT(a_close_blocks_intake, clock, reset, cmd.word_take && sts.last, !req_ready)
   // a result is only loaded into a free output register
   `HVMB_ASSERT_IMPLIES(a_emit_has_room, clock, reset, emitting, !rsp_valid || rsp_if.ready)
   // a loaded result is offered on the next cycle
   `HVMB_ASSERT_NEXT(a_emit_offers_word, clock, reset, emitting, rsp_valid)

endmodule

[tb/testbench.sv]
// self-checking testbench of the hypervector majority bundle with its own vote predictor
`timescale 1ns / 1ps
module testbench;
   import hvmb_pkg::*;

   // run length and timing bounds
   localparam int HV_WORDS    = 128;
   localparam int ITEM_TARGET = 950;
   localparam int SETTLE      = 16;       // margin for the mix and the result load after the closing word
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [WORD_W-1:0]     majority;
      logic [POSITION_W-1:0] position;
   } majority_result_type;

   logic clock = 1'b0;
   logic reset;

   hvmb_req_if req_if ();
   hvmb_rsp_if rsp_if ();
   hvmb_csr_if csr_if ();

   hypervector_majority_bundle uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor copy of the registers and the vote state
   logic [VCOUNT_W-1:0]   vcount_cfg;
   logic [WORD_W-1:0]     seed_cfg;
   logic [4:0]            vote_counts [64];
   logic [4:0]            arrivals;
   logic [WORD_W-1:0]     tie_state;
   logic [POSITION_W-1:0] position;

   majority_result_type expected_majorities [$];
   int  mismatch_count = 0;
   int  words_sent     = 0;
   int  cycle_count    = 0;
   int  burst_left     = 0;
   bit  sender_gaps_on = 1'b1;

   function automatic logic [WORD_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // splitmix64 step of the tie-break stream
   function automatic logic [WORD_W-1:0] next_tie_word();
      logic [WORD_W-1:0] z;
      tie_state = tie_state + GOLDEN_STEP;
      z = tie_state;
      z = (z ^ (z >> SHIFT_ONE)) * MIX_ONE;
      z = (z ^ (z >> SHIFT_TWO)) * MIX_TWO;
      return z ^ (z >> SHIFT_THREE);
   endfunction

   // add one accepted word to the tally, queue a majority word when the position closes
   function automatic void tally_vector_word(input logic [WORD_W-1:0] w, input logic sob);
      logic [4:0]          n;
      logic [4:0]          half;
      logic [WORD_W-1:0]   tie;
      majority_result_type res;
      n = (vcount_cfg == '0) ? 5'd1 : vcount_cfg;
      if (sob) begin
         foreach (vote_counts[b]) vote_counts[b] = '0;
         arrivals  = '0;
         position  = '0;
         tie_state = seed_cfg;
      end
      foreach (vote_counts[b]) vote_counts[b] = vote_counts[b] + 5'(w[b]);
      arrivals = arrivals + 5'd1;
      if (arrivals < n) return;
      half = n >> 1;
      tie  = next_tie_word();
      foreach (vote_counts[b]) begin
         if (vote_counts[b] > half)
            res.majority[b] = 1'b1;
         else if (!n[0] && vote_counts[b] == half)
            res.majority[b] = tie[b];
         else
            res.majority[b] = 1'b0;
      end
      res.position = position;
      expected_majorities.push_back(res);
      foreach (vote_counts[b]) vote_counts[b] = '0;
      arrivals = '0;
      position = POSITION_W'((position + 1) % HV_WORDS);
   endfunction

   // word patterns: random, tie pairs, near-unanimous, flat, sparse or dense
   function automatic logic [WORD_W-1:0] shape_word(input int style, input logic [WORD_W-1:0] base,
                                                    input int j);
      case (style)
         1:       return j[0] ? ~base : base;
         2:       return base ^ (random_word() & random_word() & random_word());
         3:       return {WORD_W{1'($urandom_range(0, 1))}};
         4:       return $urandom_range(0, 1) ? (random_word() & random_word())
                                              : (random_word() | random_word());
         default: return random_word();
      endcase
   endfunction

   // one word onto the request channel, bursts broken by random gaps while gaps are on
   task automatic send_vector_word(input logic [WORD_W-1:0] w, input logic sob);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (sender_gaps_on) begin
            gap = $urandom_range(1, 8);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid           <= 1'b1;
      req_if.vector_word     <= w;
      req_if.start_of_bundle <= sob;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      tally_vector_word(w, sob);
      words_sent++;
   endtask

   // hold the sender off until every majority word is back and the mix has settled
   task automatic wait_for_majorities();
      req_if.valid <= 1'b0;
      while (expected_majorities.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // both registers written back to back, upper bits of the count word are junk
   task automatic set_bundle_config(input logic [VCOUNT_W-1:0] count,
                                    input logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] junk;
      junk = random_word();
      csr_if.valid <= 1'b1;
      csr_if.index <= CSR_VECTOR_COUNT;
      csr_if.data  <= {junk[WORD_W-1:VCOUNT_W], count};
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      vcount_cfg = count;
      csr_if.index <= CSR_TIE_SEED;
      csr_if.data  <= seed;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      seed_cfg = seed;
      csr_if.valid <= 1'b0;
   endtask

   // reset values: one vector per bundle, every word passes straight through
   task automatic test_reset_defaults();
      send_vector_word('0, 1'b0);
      send_vector_word('1, 1'b0);
      send_vector_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      send_vector_word(64'h5555_5555_5555_5555, 1'b0);
   endtask

   // a zero count behaves as a count of one
   task automatic test_zero_count();
      wait_for_majorities();
      set_bundle_config(5'd0, random_word());
      send_vector_word(random_word(), 1'b1);
      send_vector_word(random_word(), 1'b0);
   endtask

   // even count with every bit tied, then a clear majority
   task automatic test_even_ties();
      logic [WORD_W-1:0] base;
      base = random_word();
      wait_for_majorities();
      set_bundle_config(5'd2, '1);
      send_vector_word(base, 1'b1);
      send_vector_word(~base, 1'b0);
      send_vector_word(base, 1'b0);
      send_vector_word(base, 1'b0);
   endtask

   // a new bundle throws away a half-filled position
   task automatic test_restart_mid_position();
      wait_for_majorities();
      set_bundle_config(5'd3, random_word());
      send_vector_word('1, 1'b1);
      send_vector_word('1, 1'b0);
      send_vector_word('0, 1'b1);
      send_vector_word(random_word(), 1'b0);
      send_vector_word('1, 1'b0);
   endtask

   // count dropped below the arrivals so far closes the position on the next word
   task automatic test_count_lowered();
      wait_for_majorities();
      set_bundle_config(5'd5, seed_cfg);
      send_vector_word(random_word(), 1'b1);
      send_vector_word(random_word(), 1'b0);
      send_vector_word(random_word(), 1'b0);
      wait_for_majorities();
      set_bundle_config(5'd2, seed_cfg);
      send_vector_word(random_word(), 1'b0);
   endtask

   // new seed only takes hold at the next start of bundle
   task automatic test_seed_mid_bundle();
      logic [WORD_W-1:0] base;
      base = random_word();
      wait_for_majorities();
      set_bundle_config(5'd2, random_word());
      send_vector_word(base, 1'b1);
      send_vector_word(~base, 1'b0);
      wait_for_majorities();
      set_bundle_config(5'd2, random_word());
      send_vector_word(base, 1'b0);
      send_vector_word(~base, 1'b0);
      send_vector_word(base, 1'b1);
      send_vector_word(~base, 1'b0);
   endtask

   // past the last position the index wraps and the tie stream runs on
   task automatic test_position_wrap();
      logic [WORD_W-1:0] base;
      wait_for_majorities();
      set_bundle_config(5'd2, random_word());
      for (int p = 0; p < HV_WORDS + 2; p++) begin
         base = random_word();
         for (int j = 0; j < 2; j++)
            send_vector_word(shape_word(p % 2, base, j), p == 0 && j == 0);
      end
   endtask

   // random bundles under random settings until enough words have gone in
   task automatic test_random_bundles();
      logic [VCOUNT_W-1:0] count;
      logic [WORD_W-1:0]   seed;
      logic [WORD_W-1:0]   base;
      int eff;
      int positions;
      int style;
      int extra;
      while (words_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 7))
            0:       count = 5'd1;
            1:       count = 5'd2;
            2:       count = 5'd31;
            3:       count = 5'd30;
            4:       count = 5'd0;
            default: count = 5'($urandom_range(1, 31));
         endcase
         case ($urandom_range(0, 3))
            0:       seed = '0;
            1:       seed = '1;
            default: seed = random_word();
         endcase
         wait_for_majorities();
         set_bundle_config(count, seed);
         eff = (count == '0) ? 1 : int'(count);
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 3)) begin
            positions = (eff > 8) ? $urandom_range(1, 2) : $urandom_range(1, 8);
            for (int p = 0; p < positions; p++) begin
               base  = random_word();
               style = $urandom_range(0, 4);
               for (int j = 0; j < eff; j++)
                  send_vector_word(shape_word(style, base, j),
                                   (p == 0 && j == 0) || ($urandom_range(0, 60) == 0));
               // occasional reseed between positions of a live bundle
               if ($urandom_range(0, 9) == 0) begin
                  wait_for_majorities();
                  set_bundle_config(count, random_word());
               end
            end
            // truncated position left behind for the next bundle to discard
            if (eff > 1 && $urandom_range(0, 5) == 0) begin
               extra = $urandom_range(1, eff - 1);
               repeat (extra) send_vector_word(random_word(), 1'b0);
            end
         end
      end
   endtask

   // result side: compare against the oldest expectation, stall on a pattern of its own
   initial begin
      majority_result_type exp_res;
      int rx_mode;
      int stall_left;
      int rx_cycle;
      rx_mode    = 0;
      stall_left = 0;
      rx_cycle   = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (expected_majorities.size() == 0) begin
               $display("%0t: unexpected majority word: expected none, actual %h at position %0d",
                        $time, rsp_if.majority_word, rsp_if.word_position);
               mismatch_count++;
            end else begin
               exp_res = expected_majorities.pop_front();
               if (rsp_if.majority_word !== exp_res.majority) begin
                  $display("%0t: majority_word mismatch: expected %h, actual %h",
                           $time, exp_res.majority, rsp_if.majority_word);
                  mismatch_count++;
               end
               if (rsp_if.word_position !== exp_res.position) begin
                  $display("%0t: word_position mismatch: expected %0d, actual %0d",
                           $time, exp_res.position, rsp_if.word_position);
                  mismatch_count++;
               end
            end
         end
         // stall mode, redrawn by the rx_cycle counter: free running, coin toss, long stalls
         rx_cycle++;
         if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
         case (rx_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_if.ready <= 1'b0;
               end else if ($urandom_range(0, 5) == 0) begin
                  stall_left = $urandom_range(1, 12);
                  rsp_if.ready <= 1'b0;
               end else begin
                  rsp_if.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // watchdog on a hung handshake
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      reset                  <= 1'b1;
      req_if.valid           <= 1'b0;
      req_if.vector_word     <= '0;
      req_if.start_of_bundle <= 1'b0;
      csr_if.valid           <= 1'b0;
      csr_if.index           <= CSR_VECTOR_COUNT;
      csr_if.data            <= '0;
      // predictor state after reset
      vcount_cfg = 5'd1;
      seed_cfg   = '0;
      foreach (vote_counts[b]) vote_counts[b] = '0;
      arrivals  = '0;
      tie_state = '0;
      position  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_count();
      test_even_ties();
      test_restart_mid_position();
      test_count_lowered();
      test_seed_mid_bundle();
      test_position_wrap();
      test_random_bundles();

      wait_for_majorities();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
